@@ sv/tlsc_pkg.sv @@
// Package with the types and constants of the transmit lease session controller.
package tlsc_pkg;

   localparam logic [19:0] REQUIRED_RATE = 20'd48000;

   localparam logic [1:0] OWNER_NONE = 2'd0;
   localparam logic [1:0] OWNER_THIS = 2'd1;

   localparam logic [1:0] REPLY_OK   = 2'd0;
   localparam logic [1:0] REPLY_BUSY = 2'd1;

   localparam logic [1:0] SOURCE_AUDIO = 2'd0;
   localparam logic [1:0] SOURCE_IQ    = 2'd1;

   localparam logic [1:0] PMODE_USB = 2'd0;
   localparam logic [1:0] PMODE_LSB = 2'd1;
   localparam logic [1:0] PMODE_IQ  = 2'd2;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [3:0] {
      EV_ACQUIRE    = 4'd0,
      EV_KEEPALIVE  = 4'd1,
      EV_ATTACH     = 4'd2,
      EV_DATA       = 4'd3,
      EV_KEYSTART   = 4'd4,
      EV_KEYSTOP    = 4'd5,
      EV_RELEASE    = 4'd6,
      EV_DISCONNECT = 4'd7,
      EV_TICK       = 4'd8,
      EV_RECONCILE  = 4'd9
   } event_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_DISABLED     = 4'd1,
      ST_BUSY         = 4'd2,
      ST_INVALID      = 4'd3,
      ST_STALE        = 4'd4,
      ST_NOT_READY    = 4'd5,
      ST_HW_ERROR     = 4'd6,
      ST_EXPIRED      = 4'd7,
      ST_DATA_TIMEOUT = 4'd8
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SESSION_ENABLE   = 3'd0,
      CSR_MIN_DRIVE        = 3'd1,
      CSR_MAX_DRIVE        = 3'd2,
      CSR_PREBUFFER_TARGET = 3'd3,
      CSR_DATA_TIMEOUT     = 3'd4,
      CSR_LEASE_TIMEOUT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [63:0] lease;
      logic [63:0] now_ms;
      logic [15:0] frames;
      logic [6:0]  drive_pct;
      logic [19:0] rate_hz;
      logic [1:0]  source;
      logic [1:0]  profile_mode;
      logic        arbiter_enabled;
      logic [1:0]  arbiter_owner;
      logic [1:0]  arbiter_reply;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        request_key;
      logic        release_key;
      logic        is_reserved;
      logic        is_keyed;
      logic [15:0] buffered_count;
   } rsp_item_type;

   typedef struct packed {
      logic        session_enable;
      logic [6:0]  min_drive;
      logic [6:0]  max_drive;
      logic [15:0] prebuffer_target;
      logic [31:0] data_timeout_ms;
      logic [31:0] lease_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic        reserved;
      logic [63:0] held_lease;
      logic [63:0] renewed_time;
      logic [63:0] last_data_time;
      logic        stream_attached;
      logic [15:0] frame_count;
      logic        keyed;
      logic [10:0] held_profile;
   } session_type;

   localparam session_type SESSION_CLEAR = '0;

endpackage

@@ sv/tlsc_csr.sv @@
// Configuration register file of the transmit lease session controller.
module tlsc_csr
   import tlsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SESSION_ENABLE:   cfg_in.session_enable   = csr_wdata[0];
            CSR_MIN_DRIVE:        cfg_in.min_drive        = csr_wdata[6:0];
            CSR_MAX_DRIVE:        cfg_in.max_drive        = csr_wdata[6:0];
            CSR_PREBUFFER_TARGET: cfg_in.prebuffer_target = csr_wdata[15:0];
            CSR_DATA_TIMEOUT:     cfg_in.data_timeout_ms  = csr_wdata[31:0];
            CSR_LEASE_TIMEOUT:    cfg_in.lease_timeout_ms = csr_wdata[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_enable   <= 1'b0;
         cfg_ff.min_drive        <= 7'd0;
         cfg_ff.max_drive        <= 7'd100;
         cfg_ff.prebuffer_target <= 16'd4;
         cfg_ff.data_timeout_ms  <= 32'd500;
         cfg_ff.lease_timeout_ms <= 32'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/tlsc_event_logic.sv @@
// Combinational event handling: next session state and the result for one transaction.
module tlsc_event_logic
   import tlsc_pkg::*;
(
   input  cfg_type      cfg,
   input  session_type  state,
   input  req_item_type item,
   output session_type  state_next,
   output rsp_item_type rsp
);

   logic        holder;
   logic        profile_ok;
   logic        source_ok;
   status_type  unkey_status;
   status_type  status;
   logic        request_key;
   logic        release_key;
   logic [15:0] room;
   logic [15:0] added;
   logic [63:0] data_elapsed;
   logic [63:0] lease_elapsed;
   logic        data_timed_out;
   logic        lease_expired;

   assign holder = state.reserved && (item.lease != 64'd0) && (state.held_lease == item.lease);

   assign source_ok = ((item.source == SOURCE_AUDIO) &&
                       ((item.profile_mode == PMODE_USB) || (item.profile_mode == PMODE_LSB))) ||
                      ((item.source == SOURCE_IQ) && (item.profile_mode == PMODE_IQ));

   assign profile_ok = (item.drive_pct >= cfg.min_drive) &&
                       (item.drive_pct <= cfg.max_drive) &&
                       (item.rate_hz == REQUIRED_RATE) && source_ok;

   assign unkey_status = (state.keyed && (item.arbiter_reply != REPLY_OK)) ? ST_HW_ERROR : ST_OK;

   assign room  = cfg.prebuffer_target - state.frame_count;
   assign added = (item.frames < room) ? item.frames : room;

   assign data_elapsed   = item.now_ms - state.last_data_time;
   assign lease_elapsed  = item.now_ms - state.renewed_time;
   assign data_timed_out = state.keyed && (data_elapsed >= {32'd0, cfg.data_timeout_ms});
   assign lease_expired  = lease_elapsed >= {32'd0, cfg.lease_timeout_ms};

   always_comb begin
      state_next  = state;
      status      = ST_OK;
      request_key = 1'b0;
      release_key = 1'b0;
      case (event_type'(item.mode))
         EV_ACQUIRE: begin
            if (!cfg.session_enable || !item.arbiter_enabled) begin
               status = ST_DISABLED;
            end else if (!profile_ok || (item.lease == 64'd0)) begin
               status = ST_INVALID;
            end else if (state.reserved || (item.arbiter_owner != OWNER_NONE)) begin
               status = ST_BUSY;
            end else begin
               state_next.reserved       = 1'b1;
               state_next.held_lease     = item.lease;
               state_next.renewed_time   = item.now_ms;
               state_next.last_data_time = item.now_ms;
               state_next.held_profile   = {item.profile_mode, item.source, item.drive_pct};
            end
         end
         EV_KEEPALIVE: begin
            if (!holder) begin
               status = ST_STALE;
            end else begin
               state_next.renewed_time = item.now_ms;
            end
         end
         EV_ATTACH: begin
            if (!holder) begin
               status = ST_STALE;
            end else if (state.stream_attached) begin
               status = ST_BUSY;
            end else begin
               state_next.stream_attached = 1'b1;
               state_next.frame_count     = 16'd0;
               state_next.last_data_time  = item.now_ms;
            end
         end
         EV_DATA: begin
            if (!holder) begin
               status = ST_STALE;
            end else if (!state.stream_attached || (item.frames == 16'd0)) begin
               status = ST_INVALID;
            end else begin
               if (state.frame_count < cfg.prebuffer_target) begin
                  state_next.frame_count = state.frame_count + added;
               end
               state_next.last_data_time = item.now_ms;
            end
         end
         EV_KEYSTART: begin
            if (!holder) begin
               status = ST_STALE;
            end else if (!state.stream_attached ||
                         (state.frame_count < cfg.prebuffer_target)) begin
               status = ST_NOT_READY;
            end else if (!state.keyed) begin
               request_key = 1'b1;
               if (item.arbiter_reply == REPLY_BUSY) begin
                  status = ST_BUSY;
               end else if (item.arbiter_reply != REPLY_OK) begin
                  status = ST_HW_ERROR;
               end else begin
                  state_next.keyed        = 1'b1;
                  state_next.renewed_time = item.now_ms;
               end
            end
         end
         EV_KEYSTOP: begin
            if (!holder) begin
               status = ST_STALE;
            end else begin
               status      = unkey_status;
               release_key = state.keyed;
               if (state.keyed) begin
                  state_next.keyed       = 1'b0;
                  state_next.frame_count = 16'd0;
               end
            end
         end
         EV_RELEASE: begin
            if (!holder) begin
               status = ST_STALE;
            end else begin
               status      = unkey_status;
               release_key = state.keyed;
               state_next  = SESSION_CLEAR;
            end
         end
         EV_DISCONNECT: begin
            if (state.reserved) begin
               status                     = unkey_status;
               release_key                = state.keyed;
               state_next.keyed           = 1'b0;
               state_next.stream_attached = 1'b0;
               state_next.frame_count     = 16'd0;
            end
         end
         EV_TICK: begin
            if (state.reserved && (data_timed_out || lease_expired)) begin
               release_key = state.keyed;
               state_next  = SESSION_CLEAR;
               if (unkey_status != ST_OK) begin
                  status = unkey_status;
               end else if (data_timed_out) begin
                  status = ST_DATA_TIMEOUT;
               end else begin
                  status = ST_EXPIRED;
               end
            end
         end
         EV_RECONCILE: begin
            if (state.reserved && state.keyed && (item.arbiter_owner != OWNER_THIS)) begin
               state_next = SESSION_CLEAR;
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

   always_comb begin
      rsp.status         = status;
      rsp.request_key    = request_key;
      rsp.release_key    = release_key;
      rsp.is_reserved    = state_next.reserved;
      rsp.is_keyed       = state_next.keyed;
      rsp.buffered_count = state_next.frame_count;
   end

endmodule

@@ sv/transmit_lease_session_controller.sv @@
// Top level: input register, session state, event logic and result register.
// An accepted transaction is held in the input register; its result goes to the result register.
// Throughput: one transaction per cycle while the result register is empty or its result is taken.
// While a result waits, the input register still takes one transaction and then stalls.
// Synchronous active-high reset clears the session and the handshakes and sets the configuration to defaults.
module transmit_lease_session_controller
   import tlsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_item_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_item_type               rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type      cfg;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   session_type  state_ff;
   session_type  state_in;
   session_type  state_next;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_next;
   logic         out_free;
   logic         advance;

   tlsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tlsc_event_logic u_event_logic (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_next),
      .rsp        (rsp_next)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign state_in     = advance ? state_next : state_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SESSION_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
